// ===== rtl/gic_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the gate input conditioner.
package gic_pkg;

   localparam int NumInputs     = 5;
   localparam int CntWidth      = 12;
   localparam int ElapsedWidth  = 15;
   localparam int TimerWidth    = 10;
   localparam int HoldWidth     = 14;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 12;

   // input positions in the level vectors
   localparam int IdxStop     = 0;
   localparam int IdxObstacle = 1;
   localparam int IdxOpen     = 2;
   localparam int IdxClose    = 3;
   localparam int IdxButton   = 4;

   localparam logic [CntWidth-1:0]     CntMax         = 12'd4095;
   localparam logic [CntWidth-1:0]     StopDebounce   = 12'd30;
   localparam logic [CntWidth-1:0]     ButtonDebounce = 12'd50;
   localparam logic [CntWidth-1:0]     DefaultDebounce = 12'd50;
   localparam logic [ElapsedWidth-1:0] ElapsedMax     = 15'd32767;
   localparam logic [TimerWidth-1:0]   ConfirmLimit   = 10'd901;
   localparam logic [HoldWidth-1:0]    HoldoffMin     = 14'd1200;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_OPEN_DEBOUNCE  = 3'd0,
      CSR_CLOSE_DEBOUNCE = 3'd1,
      CSR_OBST_DEBOUNCE  = 3'd2,
      CSR_INVERT_MASK    = 3'd3,
      CSR_PRESENT_MASK   = 3'd4,
      CSR_LIMITS_ENABLE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic raw_stop;
      logic raw_obstacle;
      logic raw_limit_open;
      logic raw_limit_close;
      logic raw_button;
   } req_payload_type;

   typedef struct packed {
      logic stop_pressed;
      logic obstacle_changed;
      logic obstacle_level;
      logic open_limit_rising;
      logic close_limit_rising;
      logic limits_conflict;
      logic limits_conflict_edge;
      logic button_pressed;
      logic limits_ready_flag;
      logic open_limit_level;
      logic close_limit_level;
   } rsp_payload_type;

endpackage

// ===== rtl/gic_req_if.sv =====
`timescale 1ns / 1ps
// Request channel carrying one tick of raw switch levels.
interface gic_req_if;
   logic                     valid;
   logic                     ready;
   gic_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/gic_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel carrying the conditioned events and levels of one tick.
interface gic_rsp_if;
   logic                     valid;
   logic                     ready;
   gic_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/gate_input_conditioner.sv =====
`timescale 1ns / 1ps
// Top level: switch debouncers with limit switch supervision.
//
// Each request on req_if is one millisecond tick with the raw levels of the
// stop, obstacle, open limit, close limit and button inputs. Each request
// gives exactly one response on rsp_if with press/change events, limit
// rising edges, the both-limits conflict flags and the qualified levels.
// The response is registered and shows the cycle after the request is
// taken. A request can be taken every cycle while rsp_if.ready is high; the
// output register is reloaded in the same cycle its response is taken, so
// the block then sustains one tick per clock.
// When rsp_if.ready is low with a response pending, req_if.ready drops and
// the response holds until taken.
// The csr_ port writes the six configuration registers, one per cycle; write
// only between ticks. Synchronous reset restores register defaults and
// clears all debounce and timer state; the first tick after reset primes
// the stable levels and reports no events. Limit events and levels stay low
// until max(1200, 4 x largest limit debounce) ticks pass after priming.
module gate_input_conditioner #(
   parameter int unsigned MAX_DEBOUNCE_MS = 4095
) (
   input  logic                                clock,
   input  logic                                reset,
   gic_req_if.sink                             req_if,
   gic_rsp_if.source                           rsp_if,
   input  logic                                csr_write_enable,
   input  logic [gic_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [gic_pkg::CsrDataWidth-1:0]    csr_write_data
);

   localparam int CW = gic_pkg::CntWidth;
   localparam int NI = gic_pkg::NumInputs;
   localparam logic [CW-1:0] DbCap =
      (MAX_DEBOUNCE_MS > 4095) ? gic_pkg::CntMax : CW'(MAX_DEBOUNCE_MS);

   function automatic logic [CW-1:0] clamp_db(input logic [CW-1:0] v);
      return (v > DbCap) ? DbCap : v;
   endfunction

   // configuration registers
   logic [CW-1:0] open_db_ff, close_db_ff, obst_db_ff;
   logic [3:0]    invert_ff;
   logic [NI-1:0] present_ff;
   logic [2:0]    enable_ff;

   // tick state
   logic [NI-1:0]                      last_ff, last_in;
   logic [NI-1:0]                      stable_ff, stable_in;
   logic [CW-1:0]                      cnt_ff [NI];
   logic [CW-1:0]                      cnt_in [NI];
   logic [gic_pkg::ElapsedWidth-1:0]   elapsed_ff, elapsed_in;
   logic [gic_pkg::TimerWidth-1:0]     timer_ff, timer_in;
   logic                               latched_ff, latched_in;
   logic                               primed_ff;

   logic                               rsp_valid_ff;
   gic_pkg::rsp_payload_type           rsp_ff, rsp_in;
   logic                               req_fire;

   assign req_if.ready   = !rsp_valid_ff || rsp_if.ready;
   assign req_fire       = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_db_ff  <= gic_pkg::DefaultDebounce;
         close_db_ff <= gic_pkg::DefaultDebounce;
         obst_db_ff  <= gic_pkg::DefaultDebounce;
         invert_ff   <= '0;
         present_ff  <= '1;
         enable_ff   <= '1;
      end else if (csr_write_enable) begin
         case (gic_pkg::csr_index_type'(csr_index))
            gic_pkg::CSR_OPEN_DEBOUNCE:  open_db_ff  <= csr_write_data;
            gic_pkg::CSR_CLOSE_DEBOUNCE: close_db_ff <= csr_write_data;
            gic_pkg::CSR_OBST_DEBOUNCE:  obst_db_ff  <= csr_write_data;
            gic_pkg::CSR_INVERT_MASK:    invert_ff   <= csr_write_data[3:0];
            gic_pkg::CSR_PRESENT_MASK:   present_ff  <= csr_write_data[NI-1:0];
            gic_pkg::CSR_LIMITS_ENABLE:  enable_ff   <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [NI-1:0]                 raw;
      logic [NI-1:0]                 present;
      logic [NI-1:0]                 active;
      logic [NI-1:0]                 chg;
      logic [CW-1:0]                 db [NI];
      logic [CW-1:0]                 maxdb;
      logic [gic_pkg::HoldWidth-1:0] hold;
      logic                          glob, open_en, close_en;
      logic                          ready, open_act, close_act, both;
      logic                          conflict, conflict_edge;

      glob     = enable_ff[0];
      open_en  = glob && enable_ff[1];
      close_en = glob && enable_ff[2];

      present = present_ff;
      if (!glob) begin
         present[gic_pkg::IdxOpen]  = 1'b0;
         present[gic_pkg::IdxClose] = 1'b0;
      end

      raw[gic_pkg::IdxStop]     = req_if.payload.raw_stop;
      raw[gic_pkg::IdxObstacle] = req_if.payload.raw_obstacle    ^ invert_ff[0];
      raw[gic_pkg::IdxOpen]     = req_if.payload.raw_limit_open  ^ invert_ff[1];
      raw[gic_pkg::IdxClose]    = req_if.payload.raw_limit_close ^ invert_ff[2];
      raw[gic_pkg::IdxButton]   = req_if.payload.raw_button      ^ invert_ff[3];
      raw = raw & present;

      db[gic_pkg::IdxStop]     = clamp_db(gic_pkg::StopDebounce);
      db[gic_pkg::IdxObstacle] = clamp_db(obst_db_ff);
      db[gic_pkg::IdxOpen]     = clamp_db(open_db_ff);
      db[gic_pkg::IdxClose]    = clamp_db(close_db_ff);
      db[gic_pkg::IdxButton]   = clamp_db(gic_pkg::ButtonDebounce);

      // frozen limits are skipped by the debouncers
      active = present;
      active[gic_pkg::IdxOpen]  = present[gic_pkg::IdxOpen]  && open_en;
      active[gic_pkg::IdxClose] = present[gic_pkg::IdxClose] && close_en;

      last_in    = last_ff;
      stable_in  = stable_ff;
      cnt_in     = cnt_ff;
      chg        = '0;
      elapsed_in = elapsed_ff;
      timer_in   = timer_ff;
      latched_in = latched_ff;

      if (!primed_ff) begin
         last_in    = raw;
         stable_in  = raw;
         for (int i = 0; i < NI; i++) cnt_in[i] = '0;
         elapsed_in = '0;
         timer_in   = '0;
         latched_in = 1'b0;
      end else begin
         if (elapsed_ff < gic_pkg::ElapsedMax) elapsed_in = elapsed_ff + 1'b1;
         for (int i = 0; i < NI; i++) begin
            if (!present[i]) begin
               last_in[i]   = 1'b0;
               stable_in[i] = 1'b0;
               cnt_in[i]    = '0;
            end else if (active[i]) begin
               if (raw[i] != last_ff[i]) begin
                  last_in[i] = raw[i];
                  cnt_in[i]  = '0;
               end else if (cnt_ff[i] < gic_pkg::CntMax) begin
                  cnt_in[i] = cnt_ff[i] + 1'b1;
               end
               if ((stable_ff[i] != raw[i]) && (cnt_in[i] >= db[i])) begin
                  stable_in[i] = raw[i];
                  chg[i]       = 1'b1;
               end
            end
         end
      end

      maxdb = (db[gic_pkg::IdxOpen] > db[gic_pkg::IdxClose]) ?
              db[gic_pkg::IdxOpen] : db[gic_pkg::IdxClose];
      hold  = {maxdb, 2'b00};
      if (hold < gic_pkg::HoldoffMin) hold = gic_pkg::HoldoffMin;

      ready     = elapsed_in >= {1'b0, hold};
      open_act  = open_en  && stable_in[gic_pkg::IdxOpen];
      close_act = close_en && stable_in[gic_pkg::IdxClose];
      both      = ready && open_act && close_act;

      conflict      = 1'b0;
      conflict_edge = 1'b0;
      if (glob && both) begin
         if (timer_in < gic_pkg::ConfirmLimit) timer_in = timer_in + 1'b1;
         if (timer_in >= gic_pkg::ConfirmLimit) begin
            conflict      = 1'b1;
            conflict_edge = !latched_in;
            latched_in    = 1'b1;
         end
      end else begin
         timer_in   = '0;
         latched_in = 1'b0;
      end

      rsp_in.stop_pressed         = chg[gic_pkg::IdxStop] && stable_in[gic_pkg::IdxStop];
      rsp_in.obstacle_changed     = chg[gic_pkg::IdxObstacle];
      rsp_in.obstacle_level       = stable_in[gic_pkg::IdxObstacle];
      rsp_in.open_limit_rising    = open_en && ready && !both &&
                                    chg[gic_pkg::IdxOpen] && open_act;
      rsp_in.close_limit_rising   = close_en && ready && !both &&
                                    chg[gic_pkg::IdxClose] && close_act;
      rsp_in.limits_conflict      = conflict;
      rsp_in.limits_conflict_edge = conflict_edge;
      rsp_in.button_pressed       = chg[gic_pkg::IdxButton] &&
                                    stable_in[gic_pkg::IdxButton];
      rsp_in.limits_ready_flag    = ready;
      rsp_in.open_limit_level     = ready && open_act;
      rsp_in.close_limit_level    = ready && close_act;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         stable_ff  <= '0;
         for (int i = 0; i < NI; i++) cnt_ff[i] <= '0;
         elapsed_ff <= '0;
         timer_ff   <= '0;
         latched_ff <= 1'b0;
         primed_ff  <= 1'b0;
      end else if (req_fire) begin
         last_ff    <= last_in;
         stable_ff  <= stable_in;
         cnt_ff     <= cnt_in;
         elapsed_ff <= elapsed_in;
         timer_ff   <= timer_in;
         latched_ff <= latched_in;
         primed_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/gic_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the gate input conditioner, with its bind.
module gic_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input gic_pkg::rsp_payload_type rsp_payload
);

   // a request is only refused while a response waits
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request refused with no response pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_edge_in_conflict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.limits_conflict_edge |-> rsp_payload.limits_conflict)
      else $error("conflict edge without conflict");

   a_conflict_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.limits_conflict |->
         rsp_payload.limits_ready_flag && rsp_payload.open_limit_level &&
         rsp_payload.close_limit_level && !rsp_payload.open_limit_rising &&
         !rsp_payload.close_limit_rising)
      else $error("conflict without both limits qualified");

   a_rising_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.open_limit_rising || rsp_payload.close_limit_rising) |->
         rsp_payload.limits_ready_flag &&
         (!rsp_payload.open_limit_rising || rsp_payload.open_limit_level) &&
         (!rsp_payload.close_limit_rising || rsp_payload.close_limit_level))
      else $error("limit edge without qualified level");

endmodule

bind gate_input_conditioner gic_checker u_gic_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
